[hdl/cmds_pkg.sv]
// cmds_pkg: shared widths, register indexes and inter-module structs for the
// chunk mode downsampler. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmds_pkg;

	// sample field and value space
	localparam int SAMPLE_W   = 8;
	localparam int VALUE_BITS = 8;
	localparam int NUM_VALUES = 1 << VALUE_BITS;

	// chunk length and per-value counts
	localparam int MAX_FACTOR = 1024;
	localparam int CHUNK_W    = 11;
	localparam int COUNT_W    = $clog2(MAX_FACTOR + 1);

	// result packing on the output stream
	localparam int RESULT_W = SAMPLE_W + CHUNK_W;
	localparam int OUT_W    = ((RESULT_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_W = CHUNK_W;

	typedef enum logic [0:0] {
		REG_FACTOR = 1'b0,
		REG_DEMOTE = 1'b1
	} cfg_reg_t;

	// item leaving the tally stage
	typedef struct packed {
		logic                  valid;
		logic [VALUE_BITS-1:0] value;
		logic                  last;
		logic [COUNT_W-1:0]    count;
	} tally_t;

	// control returned from the mode selector
	typedef struct packed {
		logic go;
		logic close;
	} chunk_ctl_t;

endpackage

`default_nettype wire

[hdl/chunk_mode_downsampler_core.sv]
// chunk_mode_downsampler_core: top level of the chunk mode downsampler.
// Depends on cmds_pkg, cmds_tally, cmds_select (and cmds_ram through cmds_tally).
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------------
//   s_axis   | in        | tvalid / tready        | tdata[7:0] sample, tlast end_of_series
//   m_axis   | out       | tvalid / tready        | tdata[7:0] mode_value, [18:8] chunk_length
//   cfg      | in        | cfg_we (no wait)       | cfg_index, cfg_data
//
// One sample per cycle when the output side is not stalled; a result is loaded
// into the result register as its closing sample leaves the input stage register.
// The count store is a 256-entry RAM with a per-value valid bit, all cleared at
// once when a chunk closes, so no clearing pass follows reset.
// A stalled result holds the input stage; the next sample waits in s_axis.
`timescale 1ns / 1ps
`default_nettype none

module chunk_mode_downsampler_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [cmds_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // [7:0] sample
	input  wire logic                           s_axis_tlast,  // end_of_series
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [cmds_pkg::OUT_W-1:0]          m_axis_tdata,  // [7:0] mode_value,
	                                                           // [18:8] chunk_length
	input  wire logic                           cfg_we,
	input  wire cmds_pkg::cfg_reg_t             cfg_index,
	input  wire logic [cmds_pkg::CFG_W-1:0]     cfg_data
);

	import cmds_pkg::*;

	logic [CHUNK_W-1:0]  factor_q;
	logic                demote_q;
	tally_t              item;
	chunk_ctl_t          ctl;
	logic [SAMPLE_W-1:0] out_mode;
	logic [CHUNK_W-1:0]  out_length;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= CHUNK_W'(1);
			demote_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FACTOR: begin
					factor_q <= cfg_data[CHUNK_W-1:0];
				end
				REG_DEMOTE: begin
					demote_q <= cfg_data[0];
				end
			endcase
		end
	end

	cmds_tally u_tally (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_sample (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.ctl       (ctl),
		.item      (item)
	);

	cmds_select u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.factor     (factor_q),
		.demote     (demote_q),
		.ctl        (ctl),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_mode   (out_mode),
		.out_length (out_length)
	);

	// pack the result, zero fill to whole bytes
	assign m_axis_tdata = OUT_W'({out_length, out_mode});

endmodule

`default_nettype wire

[hdl/cmds_ram.sv]
// cmds_ram: generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cmds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/cmds_tally.sv]
// cmds_tally: input register, per-value count store and count increment.
// Depends on cmds_pkg and cmds_ram.
`timescale 1ns / 1ps
`default_nettype none

module cmds_tally (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [cmds_pkg::SAMPLE_W-1:0] in_sample,
	input  wire logic                       in_last,
	input  wire cmds_pkg::chunk_ctl_t       ctl,
	output cmds_pkg::tally_t                item
);

	import cmds_pkg::*;

	logic                  valid_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic                  last_s1;
	logic                  accept;
	logic [COUNT_W-1:0]    rd_count;
	logic [COUNT_W-1:0]    old_count;
	logic [COUNT_W-1:0]    count;
	logic [NUM_VALUES-1:0] seen_q;
	logic                  fwd_valid_q;
	logic [VALUE_BITS-1:0] fwd_value_q;
	logic [COUNT_W-1:0]    fwd_count_q;
	logic                  fwd_hit;

	// take a new item whenever the stage is empty or moving on
	assign in_ready = !valid_s1 || ctl.go;
	assign accept   = in_valid && in_ready;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ctl.go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= in_sample[VALUE_BITS-1:0];
			last_s1  <= in_last;
		end
	end

	// count store: read on accept, write back the new count as the item leaves
	cmds_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (NUM_VALUES)
	) u_counts (
		.clk   (clk),
		.we    (ctl.go),
		.waddr (value_s1),
		.wdata (count),
		.re    (accept),
		.raddr (in_sample[VALUE_BITS-1:0]),
		.rdata (rd_count)
	);

	// bypass the count written at the edge the read was taken
	assign fwd_hit   = fwd_valid_q && (fwd_value_q == value_s1);
	assign old_count = !seen_q[value_s1] ? '0 : (fwd_hit ? fwd_count_q : rd_count);
	assign count     = old_count + 1'b1;

	// per-value valid bits: drop all at chunk close, mark on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= '0;
			fwd_valid_q <= 1'b0;
		end else if (ctl.go) begin
			if (ctl.close) begin
				seen_q      <= '0;
				fwd_valid_q <= 1'b0;
			end else begin
				seen_q[value_s1] <= 1'b1;
				fwd_valid_q      <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go) begin
			fwd_value_q <= value_s1;
			fwd_count_q <= count;
		end
	end

	assign item.valid = valid_s1;
	assign item.value = value_s1;
	assign item.last  = last_s1;
	assign item.count = count;

endmodule

`default_nettype wire

[hdl/cmds_select.sv]
// cmds_select: running mode trackers, chunk close decision and result register.
// Depends on cmds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmds_select (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cmds_pkg::tally_t              item,
	input  wire logic [cmds_pkg::CHUNK_W-1:0]  factor,
	input  wire logic                          demote,
	output cmds_pkg::chunk_ctl_t               ctl,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [cmds_pkg::SAMPLE_W-1:0]      out_mode,
	output logic [cmds_pkg::CHUNK_W-1:0]       out_length
);

	import cmds_pkg::*;

	logic [CHUNK_W-1:0]    fill_q;
	logic [CHUNK_W-1:0]    fill_next;
	logic [CHUNK_W-1:0]    eff_factor;
	logic [VALUE_BITS-1:0] any_value_q;
	logic [COUNT_W-1:0]    any_count_q;
	logic [VALUE_BITS-1:0] nz_value_q;
	logic [COUNT_W-1:0]    nz_count_q;
	logic [VALUE_BITS-1:0] any_value;
	logic [COUNT_W-1:0]    any_count;
	logic [VALUE_BITS-1:0] nz_value;
	logic [COUNT_W-1:0]    nz_count;
	logic                  any_win;
	logic                  nz_win;
	logic [VALUE_BITS-1:0] mode;
	logic                  out_free;

	// clamp the factor into 1..MAX_FACTOR
	always_comb begin
		if (factor == '0) begin
			eff_factor = CHUNK_W'(1);
		end else if (factor > CHUNK_W'(MAX_FACTOR)) begin
			eff_factor = CHUNK_W'(MAX_FACTOR);
		end else begin
			eff_factor = factor;
		end
	end

	assign out_free  = !out_valid || out_ready;
	assign fill_next = fill_q + 1'b1;
	assign ctl.go    = item.valid && out_free;
	assign ctl.close = item.last || (fill_next >= eff_factor);

	// update the trackers, lowest value wins a tie
	assign any_win = (item.count > any_count_q) ||
		((item.count == any_count_q) && (item.value < any_value_q));
	assign nz_win  = (item.value != '0) && ((item.count > nz_count_q) ||
		((item.count == nz_count_q) && (item.value < nz_value_q)));

	assign any_value = any_win ? item.value : any_value_q;
	assign any_count = any_win ? item.count : any_count_q;
	assign nz_value  = nz_win  ? item.value : nz_value_q;
	assign nz_count  = nz_win  ? item.count : nz_count_q;

	assign mode = (demote && (nz_count != '0)) ? nz_value : any_value;

	// hold the chunk state, clear it at close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			any_value_q <= '0;
			any_count_q <= '0;
			nz_value_q  <= '0;
			nz_count_q  <= '0;
		end else if (ctl.go) begin
			if (ctl.close) begin
				fill_q      <= '0;
				any_value_q <= '0;
				any_count_q <= '0;
				nz_value_q  <= '0;
				nz_count_q  <= '0;
			end else begin
				fill_q      <= fill_next;
				any_value_q <= any_value;
				any_count_q <= any_count;
				nz_value_q  <= nz_value;
				nz_count_q  <= nz_count;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctl.go && ctl.close) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.go && ctl.close) begin
			out_mode   <= SAMPLE_W'(mode);
			out_length <= fill_next;
		end
	end

	// an item's count never exceeds the samples seen so far in its chunk
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid |-> (item.count != '0) && (item.count <= fill_next))
		else $error("count out of range for chunk fill");

	// the nonzero mode can never be more frequent than the overall mode
	a_nz_le_any: assert property (@(posedge clk) disable iff (!arst_n)
		nz_count_q <= any_count_q)
		else $error("nonzero tracker ahead of overall tracker");

	// an open chunk always stays below the largest factor
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CHUNK_W'(MAX_FACTOR))
		else $error("chunk fill overran");

	// a result holds between one and MAX_FACTOR samples
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_length != '0) && (out_length <= CHUNK_W'(MAX_FACTOR)))
		else $error("result length out of range");

endmodule

`default_nettype wire
